### hw/rtl/assert_macros.svh
// Assertion helpers shared by the learner RTL.
// Each macro expects signals named clk and arst_n in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define MCVL_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define MCVL_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mcvl_pkg.sv
`timescale 1ns / 1ps
package mcvl_pkg;

	localparam int MAX_STEPS_DEF = 32;

	localparam int ST_W      = 10;
	localparam int PAIR_W    = 11;
	localparam int TBL_DEPTH = 2048;
	localparam int REW_W     = 16;
	localparam int VAL_W     = 32;
	localparam int VIS_W     = 16;
	localparam int GAMMA_W   = 17;
	localparam int THR_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 17;

	localparam int DVD_W = 34;
	localparam int DVS_W = 16;

	localparam logic [GAMMA_W-1:0] GAMMA_ONE = 17'd65536;
	localparam logic [THR_W-1:0]   THR_RST   = 5'd17;

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_END    = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HIT_THR  = 1'b1;

	typedef struct packed {
		logic                    seen;
		logic [VIS_W-1:0]        visit;
		logic signed [VAL_W-1:0] value;
	} row_t;

	typedef struct packed {
		logic [PAIR_W-1:0]       pair;
		logic signed [REW_W-1:0] reward;
	} step_t;

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [35:0] x);
		logic signed [VAL_W-1:0] r;
		if ((&x[35:31]) || !(|x[35:31]))
			r = x[31:0];
		else if (x[35])
			r = {1'b1, {(VAL_W-1){1'b0}}};
		else
			r = {1'b0, {(VAL_W-1){1'b1}}};
		return r;
	endfunction

endpackage

### hw/rtl/mcvl_ram.sv
`timescale 1ns / 1ps
module mcvl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/mcvl_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mcvl_div import mcvl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CW = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVD_W-1:0] acc_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, acc_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				acc_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
				acc_q <= {acc_q[DVD_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

	`MCVL_HOLDS(a_start_idle, start |-> !busy_q, "divider started while busy")

endmodule

### hw/rtl/monte_carlo_value_learner_top.sv
// Record, unused and empty-end commands go straight to the result state; a query first reads
// both action rows of its state. End of episode: each step whose pair is updated waits on the serial
// divider (one quotient bit a cycle), a repeated pair is skipped, and a pass drops the seen marks.
// One item at a time; a finished result waits in the output register while the next starts.
// Reset: arst_n clears control state, then a pass over all 2048 rows zeroes the value table
// with input stalled; configuration writes are taken throughout.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module monte_carlo_value_learner_top import mcvl_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [4:0]                  player_sum,
	input  logic [3:0]                  dealer_upcard,
	input  logic                        usable_ace,
	input  logic                        action,
	input  logic signed [REW_W-1:0]     reward,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic                        best_action,
	output logic                        known_state,
	output logic signed [VAL_W-1:0]     q_value,
	output logic [VIS_W-1:0]            visit_count,
	output logic [31:0]                 episodes,
	// configuration
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data
);

	localparam int IDX_W = $clog2(MAX_STEPS);
	localparam int CNT_W = $clog2(MAX_STEPS + 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_BUF, S_GAIN, S_CHK, S_DIV,
		S_CR, S_CB, S_CT, S_Q0, S_Q1, S_Q2, S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [GAMMA_W-1:0] disc_q;
	logic [THR_W-1:0]   thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_q <= GAMMA_ONE;
			thr_q  <= THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DISCOUNT: disc_q <= cfg_data[GAMMA_W-1:0];
				REG_HIT_THR:  thr_q  <= cfg_data[THR_W-1:0];
			endcase
		end
	end

	// episode and walk state
	logic [CNT_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        t_q;
	logic [IDX_W-1:0]        last_q;
	logic [31:0]             ep_q;
	logic [PAIR_W-1:0]       clr_q;
	logic [ST_W-1:0]         st_q;
	logic [4:0]              sum_q;
	logic                    act_q;
	logic [PAIR_W-1:0]       pair_q;
	logic signed [REW_W-1:0] fin_q;
	logic signed [REW_W-1:0] rew_q;
	logic signed [VAL_W-1:0] g_q;
	logic signed [49:0]      prod_q;
	row_t                    row_q;
	logic [VIS_W-1:0]        n_q;
	logic                    neg_q;

	// pending result, then the output register
	logic                    r_status_q, r_best_q, r_known_q;
	logic signed [VAL_W-1:0] r_q_q;
	logic [VIS_W-1:0]        r_visit_q;
	logic                    o_valid_q, o_status_q, o_best_q, o_known_q;
	logic signed [VAL_W-1:0] o_q_q;
	logic [VIS_W-1:0]        o_visit_q;
	logic [31:0]             o_ep_q;

	logic              accept;
	logic              room;
	logic              o_load;
	logic [ST_W-1:0]   st_in;
	logic [CNT_W-1:0]  cnt_m1;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign st_in    = {player_sum, dealer_upcard, usable_ace};
	assign room     = cnt_q < CNT_W'(MAX_STEPS);
	assign cnt_m1   = cnt_q - 1'b1;
	// load the output register when the result is ready and the slot is free or leaving
	assign o_load   = (state_q == S_DONE) && (!o_valid_q || !out_stall);

	// step buffer: append on record, read back at the walk index
	logic              buf_we;
	step_t             buf_wdata;
	logic [$bits(step_t)-1:0] buf_raw;
	step_t             buf_rd;

	assign buf_we    = accept && (cmd == CMD_RECORD) && room;
	assign buf_wdata = '{pair: {st_in, action}, reward: reward};
	assign buf_rd    = buf_raw;

	mcvl_ram #(
		.WIDTH ($bits(step_t)),
		.DEPTH (MAX_STEPS)
	) u_steps (
		.clk   (clk),
		.we    (buf_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (buf_wdata),
		.raddr (t_q),
		.rdata (buf_raw)
	);

	// value table: seen mark, visit count and value per pair
	logic              tbl_we;
	logic [PAIR_W-1:0] tbl_waddr;
	row_t              tbl_wdata;
	logic [PAIR_W-1:0] tbl_raddr;
	logic [$bits(row_t)-1:0] tbl_raw;
	row_t              tbl_rd;

	assign tbl_rd = tbl_raw;

	mcvl_ram #(
		.WIDTH ($bits(row_t)),
		.DEPTH (TBL_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_raw)
	);

	// return and update arithmetic
	logic [GAMMA_W-1:0]      gm;
	logic signed [49:0]      pr;
	logic signed [35:0]      gsum;
	logic [VIS_W-1:0]        n_next;
	logic signed [32:0]      d;
	logic [DVD_W-1:0]        dvd;
	logic                    div_start, div_done;
	logic [DVD_W-1:0]        div_quo;
	logic signed [35:0]      squot;
	logic signed [VAL_W-1:0] new_val;

	// clamp gamma to one
	assign gm   = (disc_q > GAMMA_ONE) ? GAMMA_ONE : disc_q;
	// round gamma*G to nearest, ties up, then add the step reward
	assign pr   = prod_q + 50'sd32768;
	assign gsum = 36'($signed(pr[49:16])) + 36'(rew_q);
	// saturating visit bump; the divisor is the new count
	assign n_next = (row_q.visit == '1) ? row_q.visit : row_q.visit + 1'b1;
	assign d      = 33'(g_q) - 33'(row_q.value);
	// magnitude plus half the divisor gives round half away from zero
	assign dvd    = 34'(d[32] ? -d : d) + 34'(n_next >> 1);
	assign div_start = (state_q == S_CHK) && !row_q.seen;
	assign squot  = neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
	assign new_val = sat32(36'(row_q.value) + squot);

	mcvl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (n_next),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		unique case (state_q)
			S_BUF, S_CB: tbl_raddr = buf_rd.pair;
			S_Q0:        tbl_raddr = {st_q, 1'b0};
			S_Q1:        tbl_raddr = {st_q, 1'b1};
			default:     tbl_raddr = pair_q;
		endcase
	end

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = pair_q;
		tbl_wdata = '{seen: 1'b1, visit: n_q, value: new_val};
		if (state_q == S_CLEAR) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_q;
			tbl_wdata = '0;
		end else if (state_q == S_DIV && div_done) begin
			tbl_we = 1'b1;
		end else if (state_q == S_CT) begin
			// drop the seen mark, keep count and value
			tbl_we    = 1'b1;
			tbl_wdata = '{seen: 1'b0, visit: tbl_rd.visit, value: tbl_rd.value};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			cnt_q      <= '0;
			t_q        <= '0;
			last_q     <= '0;
			ep_q       <= '0;
			st_q       <= '0;
			sum_q      <= '0;
			act_q      <= 1'b0;
			pair_q     <= '0;
			fin_q      <= '0;
			rew_q      <= '0;
			g_q        <= '0;
			prod_q     <= '0;
			row_q      <= '0;
			n_q        <= '0;
			neg_q      <= 1'b0;
			r_status_q <= 1'b0;
			r_best_q   <= 1'b0;
			r_known_q  <= 1'b0;
			r_q_q      <= '0;
			r_visit_q  <= '0;
			o_valid_q  <= 1'b0;
			o_status_q <= 1'b0;
			o_best_q   <= 1'b0;
			o_known_q  <= 1'b0;
			o_q_q      <= '0;
			o_visit_q  <= '0;
			o_ep_q     <= '0;
		end else begin
			// retire the output beat once taken, unless a new one replaces it
			if (!o_load && !out_stall)
				o_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						st_q       <= st_in;
						sum_q      <= player_sum;
						act_q      <= action;
						r_status_q <= 1'b0;
						r_best_q   <= 1'b0;
						r_known_q  <= 1'b0;
						r_q_q      <= '0;
						r_visit_q  <= '0;
						unique case (cmd)
							CMD_RECORD: begin
								if (room)
									cnt_q <= cnt_q + 1'b1;
								else
									r_status_q <= 1'b1;
								state_q <= S_DONE;
							end
							CMD_END: begin
								fin_q <= reward;
								g_q   <= '0;
								if (cnt_q == '0) begin
									ep_q    <= ep_q + 1'b1;
									state_q <= S_DONE;
								end else begin
									t_q     <= cnt_m1[IDX_W-1:0];
									last_q  <= cnt_m1[IDX_W-1:0];
									state_q <= S_RD;
								end
							end
							CMD_QUERY: state_q <= S_Q0;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_RD: state_q <= S_BUF;
				S_BUF: begin
					// newest step carries the final reward
					pair_q  <= buf_rd.pair;
					rew_q   <= (t_q == last_q) ? fin_q : buf_rd.reward;
					prod_q  <= g_q * $signed({1'b0, gm});
					state_q <= S_GAIN;
				end
				S_GAIN: begin
					g_q     <= sat32(gsum);
					row_q   <= tbl_rd;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (row_q.seen) begin
						// later occurrence already updated: skip
						if (t_q == '0) begin
							t_q     <= last_q;
							state_q <= S_CR;
						end else begin
							t_q     <= t_q - 1'b1;
							state_q <= S_RD;
						end
					end else begin
						n_q     <= n_next;
						neg_q   <= d[32];
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (t_q == '0) begin
							t_q     <= last_q;
							state_q <= S_CR;
						end else begin
							t_q     <= t_q - 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_CR: state_q <= S_CB;
				S_CB: begin
					pair_q  <= buf_rd.pair;
					state_q <= S_CT;
				end
				S_CT: begin
					if (t_q == '0) begin
						ep_q    <= ep_q + 1'b1;
						cnt_q   <= '0;
						state_q <= S_DONE;
					end else begin
						t_q     <= t_q - 1'b1;
						state_q <= S_CR;
					end
				end
				S_Q0: state_q <= S_Q1;
				S_Q1: begin
					row_q   <= tbl_rd;
					state_q <= S_Q2;
				end
				S_Q2: begin
					// a state is known once either action was updated
					if (row_q.visit != '0 || tbl_rd.visit != '0) begin
						r_known_q <= 1'b1;
						r_best_q  <= (row_q.value > tbl_rd.value) ? 1'b0 : 1'b1;
						r_q_q     <= act_q ? tbl_rd.value : row_q.value;
						r_visit_q <= act_q ? tbl_rd.visit : row_q.visit;
					end else begin
						r_best_q  <= (sum_q < thr_q) ? 1'b0 : 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (o_load) begin
						o_valid_q  <= 1'b1;
						o_status_q <= r_status_q;
						o_best_q   <= r_best_q;
						o_known_q  <= r_known_q;
						o_q_q      <= r_q_q;
						o_visit_q  <= r_visit_q;
						o_ep_q     <= ep_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = o_valid_q;
	assign status      = o_status_q;
	assign best_action = o_best_q;
	assign known_state = o_known_q;
	assign q_value     = o_q_q;
	assign visit_count = o_visit_q;
	assign episodes    = o_ep_q;

	`MCVL_HOLDS(a_cnt_bound, cnt_q <= CNT_W'(MAX_STEPS), "step count above buffer depth")
	`MCVL_NEXT(a_end_clears, (state_q == S_CT) && (t_q == '0), cnt_q == '0, "episode end left steps")
	`MCVL_HOLDS(a_ep_step, (ep_q != $past(ep_q)) |-> (ep_q == $past(ep_q) + 32'd1), "episode count jumped")

endmodule

### bench/monte_carlo_value_learner_top_tb.sv
`timescale 1ns / 1ps
module monte_carlo_value_learner_top_tb;
	import mcvl_pkg::*;

	// One result beat as the learner should produce it.
	typedef struct {
		logic              status;
		logic              best_action;
		logic              known_state;
		logic signed [31:0] q_value;
		logic [15:0]       visit_count;
		logic [31:0]       episodes;
	} answer_t;

	// Shadow copy of the learner: tables, episode buffer and registers.
	class learner_board;
		longint            value_tbl [TBL_DEPTH];
		int unsigned       visit_tbl [TBL_DEPTH];
		bit                state_seen [TBL_DEPTH/2];
		bit [PAIR_W-1:0]   ep_pair [MAX_STEPS_DEF];
		logic signed [15:0] ep_reward [MAX_STEPS_DEF];
		int                ep_len;
		logic [31:0]       ep_total;
		logic [16:0]       gamma;
		logic [4:0]        hit_thr;
		answer_t           pending [$];
		int                fails;

		function new();
			foreach (value_tbl[i]) begin
				value_tbl[i] = 0;
				visit_tbl[i] = 0;
			end
			foreach (state_seen[i]) state_seen[i] = 0;
			ep_len = 0;
			ep_total = 0;
			gamma = GAMMA_ONE;
			hit_thr = THR_RST;
			fails = 0;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint div_near(longint d, longint n);
			if (d >= 0) return (d + n / 2) / n;
			return -((-d + n / 2) / n);
		endfunction

		// Walk the episode newest to oldest and fold the return into the tables.
		function void close_episode(logic signed [15:0] last_reward);
			longint g, gm, q, n;
			bit     touched [TBL_DEPTH];
			int     pr;
			g = 0;
			gm = (gamma > GAMMA_ONE) ? 65536 : longint'(gamma);
			foreach (touched[i]) touched[i] = 0;
			if (ep_len > 0) ep_reward[ep_len-1] = last_reward;
			for (int t = ep_len - 1; t >= 0; t--) begin
				pr = ep_pair[t];
				g = clamp32(longint'(ep_reward[t]) + ((g * gm + 32768) >>> 16));
				// only the latest occurrence of a pair counts
				if (!touched[pr]) begin
					touched[pr] = 1;
					q = value_tbl[pr];
					if (visit_tbl[pr] < 65535) visit_tbl[pr]++;
					n = visit_tbl[pr];
					value_tbl[pr] = clamp32(q + div_near(g - q, n));
					state_seen[pr >> 1] = 1;
				end
			end
			ep_len = 0;
			ep_total++;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] data);
			if (idx == REG_DISCOUNT) gamma = data;
			else hit_thr = data[4:0];
		endfunction

		// Note an accepted input beat and queue the answer it causes.
		function void note_beat(logic [1:0] c, logic [4:0] sum, logic [3:0] up,
				logic ace, logic act, logic signed [15:0] rew);
			answer_t a;
			bit [9:0] st;
			st = {sum, up, ace};
			a = '{status: 0, best_action: 0, known_state: 0, q_value: 0,
				visit_count: 0, episodes: 0};
			if (c == CMD_RECORD) begin
				if (ep_len < MAX_STEPS_DEF) begin
					ep_pair[ep_len] = {st, act};
					ep_reward[ep_len] = rew;
					ep_len++;
				end else begin
					a.status = 1'b1;
				end
			end else if (c == CMD_END) begin
				close_episode(rew);
			end else if (c == CMD_QUERY) begin
				if (state_seen[st]) begin
					a.best_action = (value_tbl[{st, 1'b0}] > value_tbl[{st, 1'b1}]) ? 1'b0 : 1'b1;
					a.known_state = 1'b1;
					a.q_value = 32'(value_tbl[{st, act}]);
					a.visit_count = 16'(visit_tbl[{st, act}]);
				end else begin
					a.best_action = (sum < hit_thr) ? 1'b0 : 1'b1;
				end
			end
			a.episodes = ep_total;
			pending = {pending, a};
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			fails++;
		endtask

		task check_beat(answer_t got);
			answer_t w;
			if (pending.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			w = pending.pop_front();
			if (got.status !== w.status)
				report($sformatf("status %0d want %0d", got.status, w.status));
			if (got.best_action !== w.best_action)
				report($sformatf("best_action %0d want %0d", got.best_action, w.best_action));
			if (got.known_state !== w.known_state)
				report($sformatf("known_state %0d want %0d", got.known_state, w.known_state));
			if (got.q_value !== w.q_value)
				report($sformatf("q_value %0d want %0d", got.q_value, w.q_value));
			if (got.visit_count !== w.visit_count)
				report($sformatf("visit_count %0d want %0d", got.visit_count, w.visit_count));
			if (got.episodes !== w.episodes)
				report($sformatf("episodes %0d want %0d", got.episodes, w.episodes));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           cmd;
	logic [4:0]           player_sum;
	logic [3:0]           dealer_upcard;
	logic                 usable_ace;
	logic                 action;
	logic signed [15:0]   reward;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 status;
	logic                 best_action;
	logic                 known_state;
	logic signed [31:0]   q_value;
	logic [15:0]          visit_count;
	logic [31:0]          episodes;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	learner_board board;
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_go;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	bit [9:0] state_pool [12];

	monte_carlo_value_learner_top u_top (.*);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: random stall, plus one long hold-off when asked so the block backs up.
	always @(negedge clk) begin
		if (hold_go && !hold_taken && hold_left == 0) begin
			hold_taken <= 1'b1;
			hold_left <= 600;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Sample result beats at the rising edge and check them in order.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_beat('{status: status, best_action: best_action,
				known_state: known_state, q_value: q_value,
				visit_count: visit_count, episodes: episodes});
	end

	// Offer one input beat; hold it until the block takes it.
	task send_beat(logic [1:0] c, logic [4:0] sum, logic [3:0] up, logic ace,
			logic act, logic signed [15:0] rew);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		player_sum <= sum;
		dealer_upcard <= up;
		usable_ace <= ace;
		action <= act;
		reward <= rew;
		do @(posedge clk); while (in_stall);
		board.note_beat(c, sum, up, ace, act, rew);
		@(negedge clk);
	endtask

	task send_state(logic [1:0] c, bit [9:0] st, logic act, logic signed [15:0] rew);
		send_beat(c, st[9:5], st[4:1], st[0], act, rew);
	endtask

	// Drop valid and wait until every answer is back, then let the block settle.
	task drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, data);
	endtask

	// One episode, mostly over the state pool with stray beats mixed in, sometimes overfilled, then up to three queries.
	task run_episode(int len);
		bit [9:0] st;
		for (int i = 0; i < len; i++) begin
			st = ($urandom_range(9) == 0) ? 10'($urandom) : state_pool[$urandom_range(11)];
			if ($urandom_range(19) == 0)
				send_beat(2'($urandom_range(3)), 5'($urandom), 4'($urandom), 1'($urandom),
					1'($urandom), 16'($urandom));
			else
				send_state(CMD_RECORD, st, 1'($urandom), 16'($urandom_range(8191)) - 16'sd4096);
		end
		send_state(CMD_END, state_pool[0], 1'b0, 16'($urandom));
		repeat ($urandom_range(3)) begin
			st = ($urandom_range(4) == 0) ? 10'($urandom) : state_pool[$urandom_range(11)];
			send_state(CMD_QUERY, st, 1'($urandom), 16'($urandom));
		end
	endtask

	task random_phase(int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(14) == 0) ? $urandom_range(32, 36) : $urandom_range(0, 9);
			run_episode(len);
			sent += len + 3;
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_RECORD;
		player_sum = '0;
		dealer_upcard = '0;
		usable_ace = 1'b0;
		action = 1'b0;
		reward = '0;
		cfg_we = 1'b0;
		cfg_index = REG_DISCOUNT;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_go = 1'b0;
		foreach (state_pool[i]) state_pool[i] = 10'($urandom);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, each command, unknown and known queries.
		tx_idle_pct = 27;
		rx_idle_pct = 71;
		send_beat(CMD_QUERY, 5'd16, 4'd0, 1'b0, 1'b0, 16'sd0);
		send_beat(CMD_QUERY, 5'd17, 4'd15, 1'b1, 1'b1, 16'sd0);
		send_beat(CMD_END, 5'd0, 4'd0, 1'b0, 1'b0, 16'sd100);
		send_beat(CMD_RECORD, 5'd31, 4'd15, 1'b1, 1'b1, 16'sd32767);
		send_beat(CMD_RECORD, 5'd0, 4'd0, 1'b0, 1'b0, -16'sd32768);
		send_beat(CMD_RECORD, 5'd31, 4'd15, 1'b1, 1'b0, 16'sd32767);
		send_beat(CMD_RECORD, 5'd31, 4'd15, 1'b1, 1'b1, 16'sd4096);
		send_beat(CMD_END, 5'd0, 4'd0, 1'b0, 1'b0, -16'sd32768);
		send_beat(CMD_QUERY, 5'd31, 4'd15, 1'b1, 1'b1, 16'sd0);
		send_beat(CMD_QUERY, 5'd31, 4'd15, 1'b1, 1'b0, 16'sd0);
		send_beat(CMD_QUERY, 5'd0, 4'd0, 1'b0, 1'b0, 16'sd0);
		send_beat(2'd3, 5'd31, 4'd15, 1'b1, 1'b1, -16'sd1);
		send_beat(CMD_END, 5'd0, 4'd0, 1'b0, 1'b0, 16'sd0);
		drain();

		// No discount and a zero threshold: every unknown state stands.
		write_reg(REG_DISCOUNT, 17'd0);
		write_reg(REG_HIT_THR, 17'd0);
		random_phase(300);
		drain();

		// Swap idling, discount above one, top threshold, and a long receiver hold-off.
		tx_idle_pct = 71;
		rx_idle_pct = 27;
		write_reg(REG_DISCOUNT, 17'h1FFFF);
		write_reg(REG_HIT_THR, 17'd31);
		hold_go = 1'b1;
		tx_idle_pct = 0;
		random_phase(40);
		hold_go = 1'b0;
		tx_idle_pct = 71;
		random_phase(260);
		drain();

		// No idling at all, near-one discount, then exactly one.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(REG_DISCOUNT, 17'd65535);
		write_reg(REG_HIT_THR, 17'($urandom_range(31)));
		random_phase(280);
		drain();
		write_reg(REG_DISCOUNT, GAMMA_ONE);
		write_reg(REG_HIT_THR, 17'(THR_RST));
		random_phase(260);
		drain();
		repeat (100) @(negedge clk);

		if (board.fails == 0 && board.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#30ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
